// ===== rtl/core/deq_pkg.sv =====
package deq_pkg;

    // Default number of entries the deque can hold.
    localparam int DEFAULT_DEPTH = 16;

    // Field widths fixed by the interface.
    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;

    // Operation codes carried by an input word.
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY      = 3'd4;

    // Status codes reported with each result word.
    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd2;

    // Sequencer states: take a word, read both ends, load the result.
    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD
    } t_state;

    // Result control handed from the sequencer to the output stage.
    typedef struct packed {
        logic                load;
        logic                empty;
        logic                full;
        logic [STATUS_W-1:0] status;
    } t_res;

endpackage

// ===== rtl/core/deq_mem.sv =====
module deq_mem #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [IW-1:0]               i_waddr,
    input  logic [deq_pkg::WORD_W-1:0]  i_wdata,
    input  logic                        i_re,
    input  logic [IW-1:0]               i_raddr_a,
    input  logic [IW-1:0]               i_raddr_b,
    output logic [deq_pkg::WORD_W-1:0]  o_rdata_a,
    output logic [deq_pkg::WORD_W-1:0]  o_rdata_b
);
    import deq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Two registered read ports; the data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

// ===== rtl/core/deq_ctrl.sv =====
module deq_ctrl #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH,
    parameter int IW    = $clog2(DEPTH),
    parameter int OW    = $clog2(DEPTH + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [deq_pkg::OP_W-1:0]    i_opcode,
    input  logic [deq_pkg::WORD_W-1:0]  i_push_value,
    input  logic                        i_slot_free,
    output deq_pkg::t_res               o_res,
    output logic                        o_we,
    output logic [IW-1:0]               o_waddr,
    output logic [deq_pkg::WORD_W-1:0]  o_wdata,
    output logic                        o_re,
    output logic [IW-1:0]               o_raddr_a,
    output logic [IW-1:0]               o_raddr_b
);
    import deq_pkg::*;

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [OW-1:0] FULL_OCC = OW'(DEPTH);

    t_state              r_state, n_state;
    logic [IW-1:0]       r_head, n_head;
    logic [IW-1:0]       r_tail, n_tail;
    logic [OW-1:0]       r_occ, n_occ;
    logic [STATUS_W-1:0] r_status, n_status;

    logic          accept;
    logic          is_empty;
    logic          is_full;
    logic [IW-1:0] head_inc, head_dec, tail_inc, tail_dec;

    // Neighbor indices around the circle.
    assign head_inc = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
    assign head_dec = (r_head == '0) ? LAST_IDX : r_head - 1'b1;
    assign tail_inc = (r_tail == LAST_IDX) ? '0 : r_tail + 1'b1;
    assign tail_dec = (r_tail == '0) ? LAST_IDX : r_tail - 1'b1;

    assign is_empty = (r_occ == '0);
    assign is_full  = (r_occ == FULL_OCC);
    assign accept   = i_in_valid && o_in_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs; no word is taken while reset is held.
    always_comb begin
        o_in_ready = 1'b0;
        o_re       = 1'b0;
        o_res      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
            end
            S_READ: begin
                o_re = 1'b1;
            end
            S_LOAD: begin
                o_res.load   = i_slot_free;
                o_res.empty  = is_empty;
                o_res.full   = is_full;
                o_res.status = r_status;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    // Index and count update for an accepted word.
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_occ    = r_occ;
        n_status = r_status;
        o_we     = 1'b0;
        o_waddr  = r_tail;
        o_wdata  = i_push_value;
        if (accept) begin
            n_status = ST_DONE;
            case (i_opcode)
                OP_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = ST_PUSH_FULL;
                    end else begin
                        n_head  = head_dec;
                        n_occ   = r_occ + 1'b1;
                        o_we    = 1'b1;
                        o_waddr = head_dec;
                    end
                end
                OP_PUSH_REAR: begin
                    if (is_full) begin
                        n_status = ST_PUSH_FULL;
                    end else begin
                        n_tail  = tail_inc;
                        n_occ   = r_occ + 1'b1;
                        o_we    = 1'b1;
                        o_waddr = r_tail;
                    end
                end
                OP_POP_FRONT: begin
                    if (is_empty) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        n_head = head_inc;
                        n_occ  = r_occ - 1'b1;
                    end
                end
                OP_POP_REAR: begin
                    if (is_empty) begin
                        n_status = ST_POP_EMPTY;
                    end else begin
                        n_tail = tail_dec;
                        n_occ  = r_occ - 1'b1;
                    end
                end
                default: begin
                    n_status = ST_DONE;
                end
            endcase
        end
    end

    // Both ends are read in the read state, after the write has landed.
    assign o_raddr_a = r_head;
    assign o_raddr_b = tail_dec;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_occ   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_occ   <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
    end

`ifndef SYNTHESIS
    // The count never passes the capacity.
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= FULL_OCC)
        else $error("occupancy exceeds depth");

    // The tail always sits occupancy entries past the head, modulo the depth.
    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((IW + 2)'(r_head) + (IW + 2)'(r_occ) >= (IW + 2)'(DEPTH))
            ? IW'((IW + 2)'(r_head) + (IW + 2)'(r_occ) - (IW + 2)'(DEPTH))
            : IW'((IW + 2)'(r_head) + (IW + 2)'(r_occ))) == r_tail)
        else $error("head, tail and occupancy disagree");

    // An accepted word always starts the read of both ends.
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_READ) && o_re)
        else $error("accepted word not followed by a read");

    // The memory is only written by an accepted push.
    a_write_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_we |-> accept && !is_full
            && ((i_opcode == OP_PUSH_FRONT) || (i_opcode == OP_PUSH_REAR)))
        else $error("memory written without an accepted push");
`endif

endmodule

// ===== rtl/core/double_ended_queue_top.sv =====
// Bounded double-ended queue of DEPTH signed 32-bit words held in a circular
// memory with head and tail indices and an occupancy count. Each input word
// carries an opcode (push front, push rear, pop front, pop rear, query; codes
// 5 to 7 act as a query) and gives exactly one result word with the front and
// rear entries after the operation (zero when empty), empty and full flags,
// and a status: 0 done, 1 pop on empty ignored, 2 push on full dropped. An
// item passes through the accept step, which updates the indices and writes
// the memory, the read step, which reads both ends through the memory's two
// read ports, and the load step, which loads the output register once the
// output slot is free. The next word is accepted right after that, even while
// the previous result still waits in the output register; a new word is not
// taken while one is in flight. No clearing pass runs after reset.
module double_ended_queue_top #(
    parameter int DEPTH = deq_pkg::DEFAULT_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [deq_pkg::OP_W-1:0]           i_opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]  i_push_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [deq_pkg::WORD_W-1:0]  o_front_value,
    output logic signed [deq_pkg::WORD_W-1:0]  o_rear_value,
    output logic                               o_is_empty,
    output logic                               o_is_full,
    output logic [deq_pkg::STATUS_W-1:0]       o_status
);
    import deq_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int OW = $clog2(DEPTH + 1);

    t_res                res;
    logic                slot_free;
    logic                we, re;
    logic [IW-1:0]       waddr, raddr_a, raddr_b;
    logic [WORD_W-1:0]   wdata, rdata_a, rdata_b;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_front, r_rear;
    logic                r_empty, r_full;
    logic [STATUS_W-1:0] r_status;

    assign slot_free = !r_out_valid || i_out_ready;

    deq_ctrl #(
        .DEPTH (DEPTH),
        .IW    (IW),
        .OW    (OW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_opcode     (i_opcode),
        .i_push_value (i_push_value),
        .i_slot_free  (slot_free),
        .o_res        (res),
        .o_we         (we),
        .o_waddr      (waddr),
        .o_wdata      (wdata),
        .o_re         (re),
        .o_raddr_a    (raddr_a),
        .o_raddr_b    (raddr_b)
    );

    deq_mem #(
        .DEPTH (DEPTH),
        .IW    (IW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_re      (re),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (rdata_a),
        .o_rdata_b (rdata_b)
    );

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output payload; an empty deque reports zero at both ends.
    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_front  <= res.empty ? '0 : rdata_a;
            r_rear   <= res.empty ? '0 : rdata_b;
            r_empty  <= res.empty;
            r_full   <= res.full;
            r_status <= res.status;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_front_value = r_front;
    assign o_rear_value  = r_rear;
    assign o_is_empty    = r_empty;
    assign o_is_full     = r_full;
    assign o_status      = r_status;

endmodule
